FILE: src/tvti_pkg.sv
// ----------------------------------------------------------------------------
// tvti_pkg: shared types and constants
// Transaction structs, field widths and register indexes for the tensor
// volume interpolator.
// ----------------------------------------------------------------------------
package tvti_pkg;

	localparam int COMP_W        = 24;
	localparam int POS_W         = 16;
	localparam int DIM_W         = 6;
	localparam int NCOMP         = 6;
	localparam int IDX_MAX_W     = 7;
	localparam int FRAC_MAX_W    = 12;
	localparam int CFG_IDX_W     = 2;
	localparam int MAX_DIM_DEF   = 32;
	localparam int FRAC_BITS_DEF = 8;

	localparam logic [DIM_W-1:0] DIM_RST = 6'd32;

	localparam logic [CFG_IDX_W-1:0] CFG_DIM_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DIM_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DIM_Z = 2'd2;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	typedef struct packed {
		logic                     command;
		logic signed [POS_W-1:0]  pos_x;
		logic signed [POS_W-1:0]  pos_y;
		logic signed [POS_W-1:0]  pos_z;
		logic signed [COMP_W-1:0] in_xx;
		logic signed [COMP_W-1:0] in_yy;
		logic signed [COMP_W-1:0] in_zz;
		logic signed [COMP_W-1:0] in_xy;
		logic signed [COMP_W-1:0] in_xz;
		logic signed [COMP_W-1:0] in_yz;
	} in_t;

	typedef struct packed {
		logic signed [COMP_W-1:0] out_xx;
		logic signed [COMP_W-1:0] out_yy;
		logic signed [COMP_W-1:0] out_zz;
		logic signed [COMP_W-1:0] out_xy;
		logic signed [COMP_W-1:0] out_xz;
		logic signed [COMP_W-1:0] out_yz;
		logic                     inside_res;
	} out_t;

	// classified command between front and back; axis 0 is x
	typedef struct packed {
		logic                                query;
		logic                                in_bounds;
		logic [2:0][IDX_MAX_W-1:0]           base;
		logic [2:0][FRAC_MAX_W-1:0]          frac;
		logic [NCOMP-1:0][COMP_W-1:0]        comp;
	} cmd_t;

endpackage

FILE: src/tvti_fifo.sv
// ----------------------------------------------------------------------------
// tvti_fifo: small transaction queue
// Register-based FIFO with first-word fall-through.
// ----------------------------------------------------------------------------
module tvti_fifo #(
	parameter type T     = logic,
	parameter int  DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	input  T     din,
	output logic full,
	input  logic rd,
	output T     dout,
	output logic empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	T                store_q [DEPTH];
	logic [PW-1:0]   wp_q;
	logic [PW-1:0]   rp_q;
	logic [CW-1:0]   cnt_q;
	logic            do_wr;
	logic            do_rd;

	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign dout  = store_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			store_q[wp_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (do_rd) begin
				rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

FILE: src/tvti_front.sv
// ----------------------------------------------------------------------------
// tvti_front: command intake and classification
// Holds the dimension registers, drops writes outside the volume, and turns
// query positions into clamped base indexes, fractions and an inside flag.
// ----------------------------------------------------------------------------
module tvti_front #(
	parameter int MAX_DIM   = tvti_pkg::MAX_DIM_DEF,
	parameter int FRAC_BITS = tvti_pkg::FRAC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [tvti_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [tvti_pkg::DIM_W-1:0]     cfg_data,
	input  logic                           push,
	input  tvti_pkg::in_t                  item,
	output logic                           full,
	input  logic                           q_full,
	input  logic                           busy,
	output logic                           q_push,
	output tvti_pkg::cmd_t                 cmd
);

	localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int ED_W  = IDX_W + 1;
	localparam int CMP_W = 24;

	logic [tvti_pkg::DIM_W-1:0]        dim_q [3];
	logic [ED_W-1:0]                   ed    [3];
	logic signed [CMP_W-1:0]           p     [3];
	logic signed [CMP_W-1:0]           ip    [3];
	logic signed [CMP_W-1:0]           d     [3];
	logic signed [CMP_W-1:0]           b     [3];
	logic [2:0]                        in_rng;
	logic [2:0]                        in_vol;
	logic signed [tvti_pkg::POS_W-1:0] pos   [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_q[0] <= tvti_pkg::DIM_RST;
			dim_q[1] <= tvti_pkg::DIM_RST;
			dim_q[2] <= tvti_pkg::DIM_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				tvti_pkg::CFG_DIM_X: dim_q[0] <= cfg_data;
				tvti_pkg::CFG_DIM_Y: dim_q[1] <= cfg_data;
				tvti_pkg::CFG_DIM_Z: dim_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	assign pos[0] = item.pos_x;
	assign pos[1] = item.pos_y;
	assign pos[2] = item.pos_z;

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			// effective dimension: below 2 acts as 2, above MAX_DIM as MAX_DIM
			if (dim_q[a] < 6'd2) begin
				ed[a] = ED_W'(2);
			end else if (int'(dim_q[a]) > MAX_DIM) begin
				ed[a] = ED_W'(MAX_DIM);
			end else begin
				ed[a] = ED_W'(dim_q[a]);
			end
			d[a]  = signed'(CMP_W'(ed[a]));
			p[a]  = CMP_W'(pos[a]);
			ip[a] = p[a] >>> FRAC_BITS;
			b[a]  = (ip[a] < 0) ? '0 : ip[a];
			if (b[a] > d[a] - 3) begin
				b[a] = CMP_W'(d[a] - 2);
			end
			in_rng[a] = (p[a] >= 0) && (p[a] < d[a]);
			in_vol[a] = (p[a] >= 0) && (p[a] <= ((d[a] - 1) <<< FRAC_BITS));
		end
	end

	always_comb begin
		cmd.query     = item.command;
		cmd.in_bounds = &in_vol;
		for (int a = 0; a < 3; a++) begin
			// writes address with the plain index, queries with the clamped base
			if (item.command == tvti_pkg::CMD_QUERY) begin
				cmd.base[a] = tvti_pkg::IDX_MAX_W'(IDX_W'(b[a]));
			end else begin
				cmd.base[a] = tvti_pkg::IDX_MAX_W'(IDX_W'(p[a]));
			end
			cmd.frac[a] = tvti_pkg::FRAC_MAX_W'(pos[a][FRAC_BITS-1:0]);
		end
		cmd.comp[0] = item.in_xx;
		cmd.comp[1] = item.in_yy;
		cmd.comp[2] = item.in_zz;
		cmd.comp[3] = item.in_xy;
		cmd.comp[4] = item.in_xz;
		cmd.comp[5] = item.in_yz;
	end

	assign full   = q_full || busy;
	assign q_push = push && !full && ((item.command == tvti_pkg::CMD_QUERY) || (&in_rng));

endmodule

FILE: src/tvti_back.sv
// ----------------------------------------------------------------------------
// tvti_back: tensor store and interpolation sequencer
// Owns the voxel memory, runs the clearing pass, performs writes and steps
// each query through eight corner reads and seven blends.
// ----------------------------------------------------------------------------
module tvti_back #(
	parameter int MAX_DIM   = tvti_pkg::MAX_DIM_DEF,
	parameter int FRAC_BITS = tvti_pkg::FRAC_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  tvti_pkg::cmd_t cmd,
	input  logic           cmd_empty,
	output logic           cmd_pop,
	output logic           busy,
	output logic           res_push,
	output tvti_pkg::out_t res,
	input  logic           res_full
);

	localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int ADDR_W = 3 * IDX_W;
	localparam int DEPTH  = 1 << ADDR_W;
	localparam int CW     = tvti_pkg::COMP_W;
	localparam int NC     = tvti_pkg::NCOMP;
	localparam int D_W    = CW + 1;
	localparam int P_W    = D_W + FRAC_BITS + 1;
	localparam int R_W    = CW + 2;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_CLEAR = 2'd1;
	localparam logic [1:0] ST_QRY   = 2'd2;

	localparam logic [3:0] CNT_X_END = 4'd8;
	localparam logic [3:0] CNT_Y0    = 4'd9;
	localparam logic [3:0] CNT_Y1    = 4'd10;
	localparam logic [3:0] CNT_LAST  = 4'd11;

	localparam logic signed [P_W-1:0] HALF = P_W'(1) <<< (FRAC_BITS - 1);
	localparam logic signed [R_W-1:0] HI   = R_W'((R_W'(1) <<< (CW - 1)) - 1);
	localparam logic signed [R_W-1:0] LO   = R_W'(-HI - 1);

	logic [NC-1:0][CW-1:0] mem [DEPTH];
	logic [NC-1:0][CW-1:0] rdata_q;
	logic [NC-1:0][CW-1:0] a_q;
	logic [NC-1:0][CW-1:0] cx_q [4];
	logic [1:0]            st_q;
	logic [3:0]            cnt_q;
	logic [ADDR_W-1:0]     clr_q;
	tvti_pkg::cmd_t        cur_q;

	logic                  we;
	logic [ADDR_W-1:0]     waddr;
	logic [NC-1:0][CW-1:0] wdata;
	logic [ADDR_W-1:0]     raddr;
	logic [IDX_W-1:0]      rx, ry, rz;
	logic [FRAC_BITS-1:0]  uf;
	logic signed [CW-1:0]  ua [NC];
	logic signed [CW-1:0]  ub [NC];
	logic signed [D_W-1:0] dd [NC];
	logic signed [P_W-1:0] pp [NC];
	logic signed [R_W-1:0] rr [NC];
	logic [NC-1:0][CW-1:0] sat;

	assign busy    = (st_q == ST_CLEAR);
	assign cmd_pop = (st_q == ST_IDLE) && !cmd_empty;
	assign we      = busy || (cmd_pop && (cmd.query == tvti_pkg::CMD_WRITE));
	assign waddr   = busy ? clr_q : {cmd.base[0][IDX_W-1:0], cmd.base[1][IDX_W-1:0],
		cmd.base[2][IDX_W-1:0]};
	assign wdata   = busy ? '0 : cmd.comp;

	// corner index in cnt bits: bit0 x, bit1 y, bit2 z
	assign rx    = cur_q.base[0][IDX_W-1:0] + IDX_W'(cnt_q[0]);
	assign ry    = cur_q.base[1][IDX_W-1:0] + IDX_W'(cnt_q[1]);
	assign rz    = cur_q.base[2][IDX_W-1:0] + IDX_W'(cnt_q[2]);
	assign raddr = {rx, ry, rz};

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	// shared blend lanes: a + round((b - a) * f)
	always_comb begin
		unique case (cnt_q)
			CNT_Y0:   uf = cur_q.frac[1][FRAC_BITS-1:0];
			CNT_Y1:   uf = cur_q.frac[1][FRAC_BITS-1:0];
			CNT_LAST: uf = cur_q.frac[2][FRAC_BITS-1:0];
			default:  uf = cur_q.frac[0][FRAC_BITS-1:0];
		endcase
		for (int k = 0; k < NC; k++) begin
			unique case (cnt_q)
				CNT_Y0: begin
					ua[k] = cx_q[0][k];
					ub[k] = cx_q[1][k];
				end
				CNT_Y1: begin
					ua[k] = cx_q[2][k];
					ub[k] = cx_q[3][k];
				end
				CNT_LAST: begin
					ua[k] = cx_q[0][k];
					ub[k] = cx_q[2][k];
				end
				default: begin
					ua[k] = a_q[k];
					ub[k] = rdata_q[k];
				end
			endcase
			dd[k] = D_W'(ub[k]) - D_W'(ua[k]);
			pp[k] = P_W'(dd[k]) * P_W'(signed'({1'b0, uf}));
			rr[k] = R_W'(ua[k]) + R_W'((pp[k] + HALF) >>> FRAC_BITS);
			if (rr[k] > HI) begin
				sat[k] = CW'(HI);
			end else if (rr[k] < LO) begin
				sat[k] = CW'(LO);
			end else begin
				sat[k] = CW'(rr[k]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop && (cmd.query == tvti_pkg::CMD_QUERY)) begin
			cur_q <= cmd;
		end
		if (st_q == ST_QRY) begin
			if ((cnt_q != '0) && (cnt_q <= CNT_X_END)) begin
				if (cnt_q[0]) begin
					a_q <= rdata_q;
				end else begin
					cx_q[2'(cnt_q[3:1] - 3'd1)] <= sat;
				end
			end else if (cnt_q == CNT_Y0) begin
				cx_q[0] <= sat;
			end else if (cnt_q == CNT_Y1) begin
				cx_q[2] <= sat;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= ST_CLEAR;
			cnt_q <= '0;
			clr_q <= '0;
		end else begin
			unique case (st_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == ADDR_W'(DEPTH - 1)) begin
						st_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					cnt_q <= '0;
					if (cmd_pop && (cmd.query == tvti_pkg::CMD_QUERY)) begin
						st_q <= ST_QRY;
					end
				end
				ST_QRY: begin
					if (cnt_q != CNT_LAST) begin
						cnt_q <= cnt_q + 1'b1;
					end else if (!res_full) begin
						st_q  <= ST_IDLE;
						cnt_q <= '0;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign res_push       = (st_q == ST_QRY) && (cnt_q == CNT_LAST) && !res_full;
	assign res.out_xx     = sat[0];
	assign res.out_yy     = sat[1];
	assign res.out_zz     = sat[2];
	assign res.out_xy     = sat[3];
	assign res.out_xz     = sat[4];
	assign res.out_yz     = sat[5];
	assign res.inside_res = cur_q.in_bounds;

`ifndef SYNTHESIS
	a_no_pop_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_CLEAR) |-> !cmd_pop) else $error("command taken during clear");
	a_push_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> ((st_q == ST_QRY) && (cnt_q == CNT_LAST)))
		else $error("result pushed early");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_QRY) |-> (cnt_q <= CNT_LAST)) else $error("step count overrun");
	a_qry_start: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_pop && (cmd.query == tvti_pkg::CMD_QUERY)) |=>
		((st_q == ST_QRY) && (cnt_q == '0))) else $error("query did not start");
`endif

endmodule

FILE: src/tensor_volume_trilinear_interp.sv
// ----------------------------------------------------------------------------
// tensor_volume_trilinear_interp: symmetric tensor volume with trilinear query
// Stores six tensor components per voxel and returns interpolated tensors.
// ----------------------------------------------------------------------------
// Usage: after reset the voxel store is cleared one entry per cycle, and
// full stays high while the clearing pass runs; dimension writes are taken
// throughout. A write transaction is performed in the back end as it is
// taken from the command queue and yields no result; writes outside the
// volume are dropped in the front end. A query transaction is taken from
// the command queue, then the back end runs eight corner reads from the
// voxel memory (one corner, all six components, per cycle) with the x
// blends trailing them, then two y blends and the z blend on a shared set
// of six blend lanes; a full result queue holds it in the last step. A
// two-entry command queue lets new transactions enter while a query runs,
// and a two-entry result queue holds finished results until popped.
// ----------------------------------------------------------------------------
module tensor_volume_trilinear_interp #(
	parameter int MAX_DIM   = tvti_pkg::MAX_DIM_DEF,
	parameter int FRAC_BITS = tvti_pkg::FRAC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration
	input  logic                           cfg_we,
	input  logic [tvti_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [tvti_pkg::DIM_W-1:0]     cfg_data,
	// input transactions
	input  logic                           push,
	input  tvti_pkg::in_t                  item,
	output logic                           full,
	// result transactions
	output logic                           empty,
	input  logic                           pop,
	output tvti_pkg::out_t                 result
);

	tvti_pkg::cmd_t cmd_in;
	tvti_pkg::cmd_t cmd_out;
	logic           q_push;
	logic           q_full;
	logic           q_empty;
	logic           q_pop;
	logic           busy;
	logic           res_push;
	logic           res_full;
	tvti_pkg::out_t res;

	// front: config registers and classification
	tvti_front #(.MAX_DIM(MAX_DIM), .FRAC_BITS(FRAC_BITS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.push     (push),
		.item     (item),
		.full     (full),
		.q_full   (q_full),
		.busy     (busy),
		.q_push   (q_push),
		.cmd      (cmd_in)
	);

	// decouples intake from the sequencer
	tvti_fifo #(.T(tvti_pkg::cmd_t), .DEPTH(2)) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_push),
		.din    (cmd_in),
		.full   (q_full),
		.rd     (q_pop),
		.dout   (cmd_out),
		.empty  (q_empty)
	);

	// back: voxel store and blend sequencer
	tvti_back #(.MAX_DIM(MAX_DIM), .FRAC_BITS(FRAC_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_out),
		.cmd_empty (q_empty),
		.cmd_pop   (q_pop),
		.busy      (busy),
		.res_push  (res_push),
		.res       (res),
		.res_full  (res_full)
	);

	// results wait here until popped
	tvti_fifo #(.T(tvti_pkg::out_t), .DEPTH(2)) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (res_push),
		.din    (res),
		.full   (res_full),
		.rd     (pop),
		.dout   (result),
		.empty  (empty)
	);

endmodule
